// ----- rtl/core/siphash_2_4_keyed_hash_assert.svh -----
// assertion macros used by the checker file of the siphash block
`ifndef SIPHASH_2_4_KEYED_HASH_ASSERT_SVH
`define SIPHASH_2_4_KEYED_HASH_ASSERT_SVH

// same-cycle implication, quiet while reset is asserted
`define SIPH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("siphash check failed: same-cycle implication");

// next-cycle implication, quiet while reset is asserted
`define SIPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("siphash check failed: next-cycle implication");

`endif

// ----- rtl/core/siph_pkg.sv -----
// shared types, constants and round functions of the siphash block
package siph_pkg;

    localparam int WORD_W  = 64;
    localparam int COUNT_W = 4;
    localparam int LEN_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] SIP_IV0 = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] SIP_IV1 = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] SIP_IV2 = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] SIP_IV3 = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] SIP_FINAL_MARK = 64'hff;
    localparam int SIP_LEN_SHIFT = 56;

    localparam logic [COUNT_W-1:0] FULL_BYTES = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_BOUND = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } sip_state_t;

    // handoff from the message loop to the closing rounds
    typedef struct packed {
        sip_state_t        st;
        logic [WORD_W-1:0] block;
    } fin_beat_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

    function automatic sip_state_t sip_round(input sip_state_t s);
        sip_state_t t;
        t = s;
        t.a = t.a + t.b; t.b = rotl(t.b, 13); t.b = t.b ^ t.a;
        t.a = rotl(t.a, 32);
        t.c = t.c + t.d; t.d = rotl(t.d, 16); t.d = t.d ^ t.c;
        t.a = t.a + t.d; t.d = rotl(t.d, 21); t.d = t.d ^ t.a;
        t.c = t.c + t.b; t.b = rotl(t.b, 17); t.b = t.b ^ t.c;
        t.c = rotl(t.c, 32);
        return t;
    endfunction

    // one compression block: two rounds between the xor-in and xor-out
    function automatic sip_state_t sip_absorb(input sip_state_t s, input logic [WORD_W-1:0] w);
        sip_state_t t;
        t = s;
        t.d = t.d ^ w;
        t = sip_round(t);
        t = sip_round(t);
        t.a = t.a ^ w;
        return t;
    endfunction

endpackage

// ----- rtl/core/siph_absorb.sv -----
// input register and per-message mixing state loop of the siphash block
module siph_absorb (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [siph_pkg::WORD_W-1:0]       data_word,
    input  logic [siph_pkg::COUNT_W-1:0]      byte_count,
    input  logic                              last_word,
    input  logic [siph_pkg::WORD_W-1:0]       key_low,
    input  logic [siph_pkg::WORD_W-1:0]       key_high,
    output logic                              fin_valid,
    input  logic                              fin_ready,
    output siph_pkg::fin_beat_t               fin_beat
);

    logic                              in_valid_reg;
    logic [siph_pkg::WORD_W-1:0]       word_reg;
    logic [siph_pkg::COUNT_W-1:0]      count_reg;
    logic                              last_reg;

    siph_pkg::sip_state_t              mix_reg;
    siph_pkg::sip_state_t              mix_next;
    logic [siph_pkg::LEN_W-1:0]        len_reg;
    logic [siph_pkg::LEN_W-1:0]        len_next;
    logic                              in_msg_reg;
    logic                              in_msg_next;

    siph_pkg::sip_state_t              start_st;
    siph_pkg::sip_state_t              absorbed_st;
    logic [siph_pkg::LEN_W-1:0]        len_base;
    logic [siph_pkg::LEN_W-1:0]        len_sum;
    logic [siph_pkg::WORD_W-1:0]       tail;
    logic [siph_pkg::COUNT_W-1:0]      count_sat;
    logic                              full_word;
    logic                              consume;

    assign count_sat = (byte_count > siph_pkg::FULL_BYTES) ? siph_pkg::FULL_BYTES : byte_count;

    // a non-last beat only touches the loop, a last beat needs the closing stage
    assign consume  = in_valid_reg && (!last_reg || fin_ready);
    assign in_stall = in_valid_reg && !consume;

    always_comb
    begin
        start_st.a = key_low  ^ siph_pkg::SIP_IV0;
        start_st.b = key_high ^ siph_pkg::SIP_IV1;
        start_st.c = key_low  ^ siph_pkg::SIP_IV2;
        start_st.d = key_high ^ siph_pkg::SIP_IV3;
        len_base   = '0;
        if (in_msg_reg)
        begin
            start_st = mix_reg;
            len_base = len_reg;
        end
    end

    assign full_word   = !last_reg || (count_reg == siph_pkg::FULL_BYTES);
    assign absorbed_st = siph_pkg::sip_absorb(start_st, word_reg);
    assign len_sum     = len_base + (last_reg ? {4'd0, count_reg} : {4'd0, siph_pkg::FULL_BYTES});

    // leftover bytes of a short last word
    always_comb
    begin
        tail = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (!full_word && (4'(i) < count_reg))
            begin
                tail[8*i +: 8] = word_reg[8*i +: 8];
            end
        end
    end

    assign fin_valid      = in_valid_reg && last_reg;
    assign fin_beat.st    = full_word ? absorbed_st : start_st;
    assign fin_beat.block = ({56'd0, len_sum} << siph_pkg::SIP_LEN_SHIFT) | tail;

    always_comb
    begin
        mix_next    = mix_reg;
        len_next    = len_reg;
        in_msg_next = in_msg_reg;
        if (consume)
        begin
            if (last_reg)
            begin
                len_next    = '0;
                in_msg_next = 1'b0;
            end
            else
            begin
                mix_next    = absorbed_st;
                len_next    = len_sum;
                in_msg_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            len_reg      <= '0;
            in_msg_reg   <= 1'b0;
            mix_reg      <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            len_reg    <= len_next;
            in_msg_reg <= in_msg_next;
            mix_reg    <= mix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            word_reg  <= data_word;
            count_reg <= count_sat;
            last_reg  <= last_word;
        end
    end

endmodule

// ----- rtl/core/siph_final.sv -----
// closing block and finalization rounds, two rounds per stage
module siph_final (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fin_valid,
    output logic                              fin_ready,
    input  siph_pkg::fin_beat_t               fin_beat,
    output logic                              hash_valid,
    input  logic                              hash_ready,
    output logic [siph_pkg::WORD_W-1:0]       hash
);

    logic                        v1_reg, v2_reg, v3_reg, v4_reg;
    logic                        rdy1, rdy2, rdy3, rdy4;
    siph_pkg::fin_beat_t         s1_reg;
    siph_pkg::sip_state_t        s2_reg, s2_next;
    siph_pkg::sip_state_t        s3_reg, s3_next;
    siph_pkg::sip_state_t        s4_st;
    logic [siph_pkg::WORD_W-1:0] hash_reg, hash_next;

    assign rdy4 = !v4_reg || hash_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign fin_ready = rdy1;

    always_comb
    begin
        s2_next   = siph_pkg::sip_absorb(s1_reg.st, s1_reg.block);
        s2_next.c = s2_next.c ^ siph_pkg::SIP_FINAL_MARK;
    end

    assign s3_next   = siph_pkg::sip_round(siph_pkg::sip_round(s2_reg));
    assign s4_st     = siph_pkg::sip_round(siph_pkg::sip_round(s3_reg));
    assign hash_next = s4_st.a ^ s4_st.b ^ s4_st.c ^ s4_st.d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= fin_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && fin_valid) s1_reg   <= fin_beat;
        if (rdy2 && v1_reg)    s2_reg   <= s2_next;
        if (rdy3 && v2_reg)    s3_reg   <= s3_next;
        if (rdy4 && v3_reg)    hash_reg <= hash_next;
    end

    assign hash_valid = v4_reg;
    assign hash       = hash_reg;

endmodule

// ----- rtl/core/siph_mulhi.sv -----
// high half of hash times range bound from four 32x32 partial products
module siph_mulhi (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              hash_valid,
    output logic                              hash_ready,
    input  logic [siph_pkg::WORD_W-1:0]       hash,
    input  logic [siph_pkg::WORD_W-1:0]       range_bound,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [siph_pkg::WORD_W-1:0]       hash_value,
    output logic [siph_pkg::WORD_W-1:0]       scaled_value
);

    logic                        pv_reg;
    logic                        p_ready;
    logic                        ov_reg;
    logic                        o_ready;
    logic [siph_pkg::WORD_W-1:0] ph_reg;
    logic [63:0]                 hh_reg, hl_reg, lh_reg, ll_reg;
    logic [63:0]                 hh_next, hl_next, lh_next, ll_next;
    logic [33:0]                 mid;
    logic [siph_pkg::WORD_W-1:0] scaled_next;
    logic [siph_pkg::WORD_W-1:0] hash_out_reg;
    logic [siph_pkg::WORD_W-1:0] scaled_reg;

    assign o_ready    = !ov_reg || !out_stall;
    assign p_ready    = !pv_reg || o_ready;
    assign hash_ready = p_ready;

    assign hh_next = 64'(hash[63:32]) * 64'(range_bound[63:32]);
    assign hl_next = 64'(hash[63:32]) * 64'(range_bound[31:0]);
    assign lh_next = 64'(hash[31:0])  * 64'(range_bound[63:32]);
    assign ll_next = 64'(hash[31:0])  * 64'(range_bound[31:0]);

    assign mid = {2'd0, hl_reg[31:0]} + {2'd0, lh_reg[31:0]} + {2'd0, ll_reg[63:32]};
    assign scaled_next = hh_reg + {32'd0, hl_reg[63:32]} + {32'd0, lh_reg[63:32]}
                       + {62'd0, mid[33:32]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (p_ready) pv_reg <= hash_valid;
            if (o_ready) ov_reg <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ready && hash_valid)
        begin
            ph_reg <= hash;
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
        end
        if (o_ready && pv_reg)
        begin
            hash_out_reg <= ph_reg;
            scaled_reg   <= scaled_next;
        end
    end

    assign out_valid    = ov_reg;
    assign hash_value   = hash_out_reg;
    assign scaled_value = scaled_reg;

endmodule

// ----- rtl/core/siphash_2_4_keyed_hash.sv -----
// top level of the siphash-2-4 keyed hash block with range scaling
// SipHash-2-4 over a stream of little-endian 64-bit words, one beat per clock
// sustained while in_stall stays low. Every beat is registered on entry; the
// next cycle selects either the running mixing state or the key-derived start
// state and runs two SipRounds, and that loop (select plus two rounds, eight
// 64-bit adds four deep) sets the clock. Non-last beats end there and give no
// result. A last beat hands its state and closing block to a four-stage
// finalization chain (closing block, then 2+2 finalization rounds, then the
// xor fold), followed by a partial-product stage and a sum stage for the
// scaled value. Messages may follow each other with no gap. The key is loaded
// into the mixing state at the first beat of each message and range_bound is
// read when the hash reaches the multiply stage, so the user must write
// configuration only while no beat is in flight; the block does not enforce it.
// A byte_count above eight counts as eight, short non-last beats are mixed as
// full words, and bytes beyond byte_count in a last beat are masked off.
module siphash_2_4_keyed_hash (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_write,
    input  logic [siph_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [siph_pkg::WORD_W-1:0]          cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [siph_pkg::WORD_W-1:0]          data_word,
    input  logic [siph_pkg::COUNT_W-1:0]         byte_count,
    input  logic                                 last_word,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [siph_pkg::WORD_W-1:0]          hash_value,
    output logic [siph_pkg::WORD_W-1:0]          scaled_value
);

    // configuration registers, cleared by reset
    logic [siph_pkg::WORD_W-1:0] key_low_reg;
    logic [siph_pkg::WORD_W-1:0] key_high_reg;
    logic [siph_pkg::WORD_W-1:0] range_bound_reg;

    // handoff between the message loop and the finalization chain
    logic                        fin_valid;
    logic                        fin_ready;
    siph_pkg::fin_beat_t         fin_beat;

    // handoff between the finalization chain and the multiplier
    logic                        hash_valid;
    logic                        hash_ready;
    logic [siph_pkg::WORD_W-1:0] hash;

    // writes to an index past the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg     <= '0;
            key_high_reg    <= '0;
            range_bound_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                siph_pkg::REG_KEY_LOW:     key_low_reg     <= cfg_data;
                siph_pkg::REG_KEY_HIGH:    key_high_reg    <= cfg_data;
                siph_pkg::REG_RANGE_BOUND: range_bound_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // input register plus the two-round mixing loop
    siph_absorb u_absorb (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last_word  (last_word),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .fin_valid  (fin_valid),
        .fin_ready  (fin_ready),
        .fin_beat   (fin_beat)
    );

    // closing block, finalization rounds and xor fold
    siph_final u_final (
        .clk        (clk),
        .rst_n      (rst_n),
        .fin_valid  (fin_valid),
        .fin_ready  (fin_ready),
        .fin_beat   (fin_beat),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash       (hash)
    );

    // range scaling and the output register
    siph_mulhi u_mulhi (
        .clk          (clk),
        .rst_n        (rst_n),
        .hash_valid   (hash_valid),
        .hash_ready   (hash_ready),
        .hash         (hash),
        .range_bound  (range_bound_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hash_value   (hash_value),
        .scaled_value (scaled_value)
    );

endmodule

// ----- rtl/core/siph_checker.sv -----
// port-level checker for the siphash block and its bind
`include "siphash_2_4_keyed_hash_assert.svh"

module siph_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 last_word,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic [siph_pkg::WORD_W-1:0]          hash_value,
    input  logic [siph_pkg::WORD_W-1:0]          scaled_value
);

    // last beats taken whose result has not been delivered yet
    logic [3:0] pend_reg;
    logic [3:0] pend_next;
    logic       last_in;
    logic       res_out;

    assign last_in = in_valid && !in_stall && last_word;
    assign res_out = out_valid && !out_stall;

    always_comb
    begin
        pend_next = pend_reg;
        if (last_in && !res_out)
        begin
            pend_next = pend_reg + 4'd1;
        end
        else if (res_out && !last_in)
        begin
            pend_next = pend_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a held result keeps its payload
    `SIPH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(hash_value) && $stable(scaled_value))

    // input backs up only when the whole chain is full behind a stalled result
    `SIPH_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // no result without a last beat that is still owed one
    `SIPH_ASSERT_IMPLY(a_no_extra, clk, rst_n, out_valid, pend_reg != 4'd0)

    // the pipeline holds at most seven messages in flight
    `SIPH_ASSERT_IMPLY(a_pend_bound, clk, rst_n, 1'b1, pend_reg <= 4'd7)

endmodule

bind siphash_2_4_keyed_hash siph_checker u_siph_checker (.*);

// ----- dv/siphash_2_4_keyed_hash_test.sv -----
// self-checking testbench for the siphash-2-4 keyed hash block with range scaling
module siphash_2_4_keyed_hash_test;

    // siphash initialization words, xored with the key at message start
    localparam logic [63:0] INIT_A = 64'h736f6d6570736575;
    localparam logic [63:0] INIT_B = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT_C = 64'h6c7967656e657261;
    localparam logic [63:0] INIT_D = 64'h7465646279746573;
    localparam logic [63:0] CLOSE_MARK = 64'hff;
    localparam int LENGTH_POS = 56;

    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
    // wait after the last digest, kept well above the block latency
    localparam int SETTLE_CYCLES = 12;
    // cycles with no beat on either side before the run is declared hung
    localparam int STUCK_LIMIT = 2000;
    // length of the receiver hold-off that fills the pipeline
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [63:0] hash;
        logic [63:0] scaled;
    } digest_t;

    // running siphash state plus a queue of digests not yet seen at the output
    class hash_scoreboard;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [63:0] bound;
        logic [63:0] va, vb, vc, vd;
        logic [7:0]  msg_len;
        bit          open_msg;
        digest_t     digests[$];
        int          mismatches;
        int          checked;

        function new();
            key_lo = '0;
            key_hi = '0;
            bound = '0;
            va = '0;
            vb = '0;
            vc = '0;
            vd = '0;
            msg_len = '0;
            open_msg = 1'b0;
            mismatches = 0;
            checked = 0;
        endfunction

        function logic [63:0] rol(logic [63:0] x, int n);
            return (x << n) | (x >> (64 - n));
        endfunction

        function void mix_round();
            va = va + vb; vb = rol(vb, 13); vb = vb ^ va; va = rol(va, 32);
            vc = vc + vd; vd = rol(vd, 16); vd = vd ^ vc;
            va = va + vd; vd = rol(vd, 21); vd = vd ^ va;
            vc = vc + vb; vb = rol(vb, 17); vb = vb ^ vc; vc = rol(vc, 32);
        endfunction

        function void compress(logic [63:0] w);
            vd = vd ^ w;
            mix_round();
            mix_round();
            va = va ^ w;
        endfunction

        function void write_reg(logic [siph_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
            case (idx)
                siph_pkg::REG_KEY_LOW:     key_lo = val;
                siph_pkg::REG_KEY_HIGH:    key_hi = val;
                siph_pkg::REG_RANGE_BOUND: bound = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return digests.size();
        endfunction

        // fold one accepted beat into the state; a last beat queues a digest
        function void note_word(logic [63:0] data, logic [3:0] cnt, logic last);
            logic [3:0]   n;
            logic [63:0]  tail;
            logic [127:0] prod;
            digest_t      dg;
            n = (cnt > siph_pkg::FULL_BYTES) ? siph_pkg::FULL_BYTES : cnt;
            if (!open_msg)
            begin
                va = key_lo ^ INIT_A;
                vb = key_hi ^ INIT_B;
                vc = key_lo ^ INIT_C;
                vd = key_hi ^ INIT_D;
                msg_len = '0;
                open_msg = 1'b1;
            end
            if (!last)
            begin
                compress(data);
                msg_len = msg_len + 8'd8;
                return;
            end
            msg_len = msg_len + 8'(n);
            if (n == siph_pkg::FULL_BYTES)
            begin
                compress(data);
                tail = '0;
            end
            else
                tail = data & ((64'd1 << (8 * n)) - 64'd1);
            compress((64'(msg_len) << LENGTH_POS) | tail);
            vc = vc ^ CLOSE_MARK;
            repeat (4) mix_round();
            dg.hash = va ^ vb ^ vc ^ vd;
            prod = {64'd0, dg.hash} * {64'd0, bound};
            dg.scaled = prod[127:64];
            digests.push_back(dg);
            open_msg = 1'b0;
            msg_len = '0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [63:0] hash, logic [63:0] scaled);
            digest_t dg;
            if (digests.size() == 0)
            begin
                report($sformatf("result %h with no message pending", hash));
                return;
            end
            dg = digests.pop_front();
            checked++;
            if (hash !== dg.hash)
                report($sformatf("hash_value %h, predicted %h", hash, dg.hash));
            if (scaled !== dg.scaled)
                report($sformatf("scaled_value %h, predicted %h", scaled, dg.scaled));
        endtask

        task flush();
            while (digests.size() > 0)
            begin
                report($sformatf("hash %h never came out", digests[0].hash));
                void'(digests.pop_front());
            end
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write;
    logic [siph_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [siph_pkg::WORD_W-1:0]    cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic [siph_pkg::WORD_W-1:0]    data_word;
    logic [siph_pkg::COUNT_W-1:0]   byte_count;
    logic                           last_word;
    logic                           out_valid;
    logic                           out_stall;
    logic [siph_pkg::WORD_W-1:0]    hash_value;
    logic [siph_pkg::WORD_W-1:0]    scaled_value;

    hash_scoreboard sb;

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_len;
    bit running;
    int stuck;
    int words_sent;
    int messages_sent;
    int cfg_writes;

    siphash_2_4_keyed_hash dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_word    (data_word),
        .byte_count   (byte_count),
        .last_word    (last_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hash_value   (hash_value),
        .scaled_value (scaled_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls at the current rate, or one long hold-off
    // when requested; the hold is counted here so the sender keeps going
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                out_stall = 1'b1;
                repeat (hold_len - 1) @(negedge clk);
                hold_len = 0;
            end
            else
                out_stall = ($urandom_range(99) < rx_stall_pct);
        end
    end

    // every result beat is checked against the oldest predicted digest
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(hash_value, scaled_value);
    end

    // watchdog: count cycles in which no beat moves on either channel
    always @(posedge clk)
    begin
        if (!running || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= STUCK_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", STUCK_LIMIT);
            $display("** siphash_2_4_keyed_hash: FAILED **");
            $finish;
        end
    end

    // one register write, starting and ending on a falling edge
    task automatic cfg_put(logic [siph_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write = 1'b0;
        sb.write_reg(idx, val);
        cfg_writes++;
    endtask

    task automatic set_regs(logic [63:0] k0, logic [63:0] k1, logic [63:0] rb);
        cfg_put(siph_pkg::REG_KEY_LOW, k0);
        cfg_put(siph_pkg::REG_KEY_HIGH, k1);
        cfg_put(siph_pkg::REG_RANGE_BOUND, rb);
    endtask

    // offer one beat after a random gap; valid is left high on return so
    // back-to-back beats keep it asserted, and drain() drops it
    task automatic send_word(logic [63:0] data, logic [3:0] cnt, logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        data_word = data;
        byte_count = cnt;
        last_word = last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(data, cnt, last);
        words_sent++;
        if (last)
            messages_sent++;
        @(negedge clk);
    endtask

    // stop offering, wait for every predicted digest, then let the
    // pipeline settle so a register write finds nothing in flight
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [63:0] rand_data();
        case ($urandom_range(15))
            0: return '0;
            1: return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mostly well-formed messages: full body words and a last word of
    // 0..8 bytes; some short body words and oversized counts as noise
    task automatic random_message();
        int len;
        int pick;
        int i;
        logic [3:0] n;
        pick = $urandom_range(99);
        if (pick < 80)
            len = $urandom_range(4, 1);
        else if (pick < 95)
            len = $urandom_range(12, 5);
        else
            len = $urandom_range(40, 30);  // long messages; from 33 words on the length byte wraps
        for (i = 0; i < len - 1; i++)
        begin
            if ($urandom_range(9) == 0)
                n = 4'($urandom_range(15));
            else
                n = siph_pkg::FULL_BYTES;
            send_word(rand_data(), n, 1'b0);
        end
        if ($urandom_range(4) == 0)
            n = 4'($urandom_range(15, 9));
        else
            n = 4'($urandom_range(8));
        send_word(rand_data(), n, 1'b1);
    endtask

    task automatic run_phase(int items, int tx_pct, int rx_pct);
        int start;
        start = words_sent;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        while (words_sent - start < items)
            random_message();
        drain();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        data_word = '0;
        byte_count = '0;
        last_word = 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_len = 0;
        running = 1'b0;
        stuck = 0;
        words_sent = 0;
        messages_sent = 0;
        cfg_writes = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        running = 1'b1;

        // directed part: standard test key, full-range bound
        set_regs(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, ALL_ONES);
        send_word(ALL_ONES, 4'd0, 1'b1);               // empty message, data masked off
        send_word(64'h0706050403020100, siph_pkg::FULL_BYTES, 1'b1);
        send_word(ALL_ONES, 4'd15, 1'b1);              // count above eight saturates
        send_word(ALL_ONES, 4'd3, 1'b1);
        send_word(ALL_ONES, 4'd7, 1'b1);
        send_word('0, siph_pkg::FULL_BYTES, 1'b0);
        send_word(rand_data(), 4'd5, 1'b1);
        send_word(ALL_ONES, 4'd2, 1'b0);               // short body word mixed as full
        send_word('0, siph_pkg::FULL_BYTES, 1'b1);
        send_word(rand_data(), 4'd12, 1'b0);
        send_word(rand_data(), 4'd0, 1'b1);
        drain();

        // key changed while a message is open: old key stays for that message
        send_word(rand_data(), siph_pkg::FULL_BYTES, 1'b0);
        drain();
        cfg_put(siph_pkg::REG_KEY_LOW, ALL_ONES);
        cfg_put(siph_pkg::REG_KEY_HIGH, '0);
        send_word(rand_data(), 4'd4, 1'b1);
        send_word(rand_data(), 4'd6, 1'b1);
        drain();

        // zero bound and bound of one both force a zero scaled value
        cfg_put(siph_pkg::REG_RANGE_BOUND, '0);
        send_word(rand_data(), siph_pkg::FULL_BYTES, 1'b1);
        drain();
        cfg_put(siph_pkg::REG_RANGE_BOUND, 64'd1);
        send_word(ALL_ONES, siph_pkg::FULL_BYTES, 1'b1);
        drain();

        // random part, one register setting and idle mix per phase
        set_regs('0, '0, '0);
        run_phase(250, 0, 0);
        set_regs(ALL_ONES, ALL_ONES, ALL_ONES);
        run_phase(250, 54, 0);
        set_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        run_phase(250, 0, 54);
        set_regs({$urandom, $urandom}, {$urandom, $urandom}, 64'd1);
        run_phase(250, 13, 13);

        // back-pressure: receiver holds off while the sender keeps offering
        set_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        hold_len = HOLD_CYCLES;
        run_phase(230, 0, 0);

        sb.flush();
        $display("covered %0d words in %0d messages, %0d digests checked, %0d register writes",
                 words_sent, messages_sent, sb.checked, cfg_writes);
        $display("idle mixes: none, sender only, receiver only, both, and a %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (sb.mismatches == 0)
            $display("** siphash_2_4_keyed_hash: PASSED **");
        else
            $display("** siphash_2_4_keyed_hash: FAILED **");
        $finish;
    end

endmodule
